@@ rtl/core/bm3_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm3_pkg
// Shared types and constants for the 3x3 binary morphology block.
// ----------------------------------------------------------------------------
package bm3_pkg;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 12;
  localparam int PIXEL_W    = 8;
  localparam int ROW_W      = 12;
  localparam int OUT_COL_W  = 10;
  localparam int FW_W       = 11;

  localparam logic [CFG_ADDR_W-1:0] REG_MODE         = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 2'd2;

  localparam logic [PIXEL_W-1:0] FG_PIXEL = 8'hFF;
  localparam logic [PIXEL_W-1:0] BG_PIXEL = 8'h00;

  localparam int WIDTH_MIN    = 3;
  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_MIN   = 3;
  localparam int HEIGHT_RESET = 480;

  localparam logic [8:0] WIN_FULL = 9'h1FF;

  // Result slots of one input, in emission order.
  typedef enum logic [1:0] {
    SLOT_ABOVE_LEFT,
    SLOT_LEFT,
    SLOT_ABOVE,
    SLOT_HERE
  } slot_t;

  // Per-item position flags; index 0 is the oldest row / column of the window.
  typedef struct packed {
    logic [2:0] row_in;
    logic [2:0] col_in;
    logic [3:0] emit;
  } pos_flags_t;

endpackage

@@ rtl/core/binary_morphology_3x3.sv @@
`timescale 1ns / 1ps
// Pipeline: an input is registered in the window stage, its results in the
//   result bundle; results trail the input raster by one row and one column.
// Throughput: one pixel per cycle while the output is ready, bounded by one
//   result per cycle at the output (two results per pixel at a row's last
//   column and on the last row, four at the last row's last column).
// Reset: clears position, window, output queue and registers to their defaults;
//   line stores are not cleared: no unwritten bit read there reaches a result.
// ----------------------------------------------------------------------------
// binary_morphology_3x3
// 3x3 binary erosion / dilation over a raster pixel stream, with two line
// stores in one 2-bit wide synchronous memory and a 9-bit window register.
// ----------------------------------------------------------------------------
module binary_morphology_3x3
  import bm3_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  // tdata: pixel[7:0]
  input  logic [7:0]            s_axis_tdata,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: out_pixel[7:0], out_row[19:8], out_col[29:20], zero[31:30]
  output logic [31:0]           m_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic                  m_axis_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int COL_W   = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 2;
  localparam int W_RST   = (MAX_WIDTH < WIDTH_RESET) ? MAX_WIDTH : WIDTH_RESET;

  // configuration
  logic             mode;
  logic [COL_W-1:0] w_last;
  logic [ROW_W-1:0] h_last;
  logic [COL_W-1:0] w_last_next;
  logic [ROW_W-1:0] h_last_next;
  logic             cfg_hit;

  // position of the next input
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  pos_flags_t       flags_in;

  // line store memory: bit 0 previous row, bit 1 the row before
  logic [1:0]       lmem [MAX_WIDTH];
  logic [1:0]       rd;

  // window stage
  logic             b_v;
  logic             b_pix;
  logic [COL_W-1:0] b_col;
  logic [ROW_W-1:0] b_row;
  pos_flags_t       b_flags;
  logic [8:0]       win;
  logic [8:0]       win_next;
  logic [8:0]       mw;
  logic [3:0]       val_next;
  logic             b_go;
  logic             in_acc;

  // result bundle
  logic [3:0]           pend;
  logic [3:0]           bval;
  logic [ROW_W-1:0]     br;
  logic [ROW_W-1:0]     brm1;
  logic [OUT_COL_W-1:0] bc;
  logic [OUT_COL_W-1:0] bcm1;
  logic                 bnd_free;
  slot_t                head;
  logic                 out_acc;

  // ---------------------------------------------------------------- config
  assign cfg_hit = cfg_we && (cfg_addr == REG_MODE || cfg_addr == REG_FRAME_WIDTH ||
                              cfg_addr == REG_FRAME_HEIGHT);

  always_comb begin
    int fw;
    fw = int'(cfg_wdata[FW_W-1:0]);
    if (fw < WIDTH_MIN) begin
      fw = WIDTH_MIN;
    end else if (fw > MAX_WIDTH) begin
      fw = MAX_WIDTH;
    end
    w_last_next = COL_W'(fw - 1);
    if (cfg_wdata < ROW_W'(HEIGHT_MIN)) begin
      h_last_next = ROW_W'(HEIGHT_MIN - 1);
    end else begin
      h_last_next = cfg_wdata - ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= 1'b0;
      w_last <= COL_W'(W_RST - 1);
      h_last <= ROW_W'(HEIGHT_RESET - 1);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MODE:         mode   <= cfg_wdata[0];
        REG_FRAME_WIDTH:  w_last <= w_last_next;
        REG_FRAME_HEIGHT: h_last <= h_last_next;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- input side
  assign bnd_free      = (pend == 4'd0) || (m_axis_tready && ((pend & (pend - 4'd1)) == 4'd0));
  assign b_go          = b_v && bnd_free;
  assign s_axis_tready = !b_v || b_go;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    logic r1, c1, lr, lc;
    r1 = (row != ROW_W'(0));
    c1 = (col != COL_W'(0));
    lr = (row == h_last);
    lc = (col == w_last);
    flags_in.row_in = {r1 && !lr, row >= ROW_W'(2), row >= ROW_W'(3)};
    flags_in.col_in = {c1 && !lc, col >= COL_W'(2), col >= COL_W'(3)};
    flags_in.emit   = {r1 && lc && lr, r1 && lc, r1 && c1 && lr, r1 && c1};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      b_v <= 1'b0;
    end else begin
      if (cfg_hit) begin
        col <= '0;
        row <= '0;
      end else if (in_acc) begin
        if (col == w_last) begin
          col <= '0;
          row <= (row == h_last) ? ROW_W'(0) : row + ROW_W'(1);
        end else begin
          col <= col + COL_W'(1);
        end
      end
      if (in_acc) begin
        b_v <= 1'b1;
      end else if (b_go) begin
        b_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      b_pix   <= (s_axis_tdata == FG_PIXEL);
      b_col   <= col;
      b_row   <= row;
      b_flags <= flags_in;
    end
  end

  // Read at accept, write back when the item leaves the window stage.
  // Successive items differ in column, so no read meets a pending write.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd <= lmem[col];
    end
    if (b_go) begin
      lmem[b_col] <= {rd[0], b_pix};
    end
  end

  // ---------------------------------------------------------------- window
  assign win_next = {b_pix, win[8], win[7], rd[0], win[5], win[4], rd[1], win[2], win[1]};

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      mw[i] = win_next[i] && b_flags.row_in[i / 3] && b_flags.col_in[i % 3];
    end
    if (mode) begin
      val_next[0] = |mw;
      val_next[1] = |mw[8:3];
      val_next[2] = mw[1] || mw[2] || mw[4] || mw[5] || mw[7] || mw[8];
      val_next[3] = mw[4] || mw[5] || mw[7] || mw[8];
    end else begin
      val_next[0] = b_flags.row_in[1] && b_flags.col_in[1] && (win_next == WIN_FULL);
      val_next[3:1] = 3'b000;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (cfg_hit) begin
      win <= '0;
    end else if (b_go) begin
      win <= win_next;
    end
  end

  // ---------------------------------------------------------------- result bundle
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 4'd0;
    end else if (b_go) begin
      pend <= b_flags.emit;
    end else if (out_acc) begin
      pend <= pend & (pend - 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (b_go) begin
      bval <= val_next;
      br   <= b_row;
      brm1 <= b_row - ROW_W'(1);
      bc   <= OUT_COL_W'(b_col);
      bcm1 <= OUT_COL_W'(b_col - COL_W'(1));
    end
  end

  always_comb begin
    priority if (pend[0]) begin
      head = SLOT_ABOVE_LEFT;
    end else if (pend[1]) begin
      head = SLOT_LEFT;
    end else if (pend[2]) begin
      head = SLOT_ABOVE;
    end else begin
      head = SLOT_HERE;
    end
  end

  always_comb begin
    logic [ROW_W-1:0]     orow;
    logic [OUT_COL_W-1:0] ocol;
    unique case (head)
      SLOT_ABOVE_LEFT: begin
        orow = brm1;
        ocol = bcm1;
      end
      SLOT_LEFT: begin
        orow = br;
        ocol = bcm1;
      end
      SLOT_ABOVE: begin
        orow = brm1;
        ocol = bc;
      end
      default: begin
        orow = br;
        ocol = bc;
      end
    endcase
    m_axis_tvalid = (pend != 4'd0);
    m_axis_tlast  = (head == SLOT_HERE);
    m_axis_tdata  = {2'b00, ocol, orow, bval[head] ? FG_PIXEL : BG_PIXEL};
  end

endmodule

@@ rtl/core/bm3_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm3_checker
// Port-level checks for binary_morphology_3x3, bound to the top level.
// ----------------------------------------------------------------------------
module bm3_checker
  import bm3_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic        m_axis_tlast
);

  // stalled transaction holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output transaction changed while stalled");

  a_binary: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[7:0] == FG_PIXEL || m_axis_tdata[7:0] == BG_PIXEL)
      && m_axis_tdata[31:30] == 2'b00)
    else $error("result pixel not binary or padding set");

  // frame end lies at the last row and column, never on row or column 0
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[19:8] != 12'd0
      && m_axis_tdata[29:20] != 10'd0)
    else $error("frame end flagged at a border start");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind binary_morphology_3x3 bm3_checker u_bm3_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tlast  (m_axis_tlast)
);

@@ verif/binary_morphology_3x3_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_morphology_3x3_tb
// Self-checking bench for the 3x3 binary erosion / dilation block. A local
// predictor tracks line stores, window and frame position, and queues the
// expected result pixels for every accepted input transaction. Reset
// defaults, directed frames, size clamping, random frames under several idle
// mixes and a long output hold-off are run in turn.
// ----------------------------------------------------------------------------
module binary_morphology_3x3_tb;
  import bm3_pkg::*;

  localparam int MAX_WIDTH     = 1024;
  localparam int HEIGHT_MAX    = 4095;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 200;
  localparam int QUIET_LIMIT   = 2000;

  localparam logic [CFG_ADDR_W-1:0] REG_NONE = 2'd3;

  typedef struct packed {
    logic [7:0]  value;
    logic [11:0] row;
    logic [9:0]  col;
    logic        last;
  } morph_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic [7:0]            s_axis_tdata = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [31:0]           m_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic                  m_axis_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // predictor state
  logic          row_above  [MAX_WIDTH] = '{default: 1'b0};
  logic          row_above2 [MAX_WIDTH] = '{default: 1'b0};
  logic [8:0]    nb_window = '0;
  int            pos_row = 0;
  int            pos_col = 0;
  logic          dilate_mode = 1'b0;
  logic [10:0]   cfg_width = 11'(WIDTH_RESET);
  logic [11:0]   cfg_height = 12'(HEIGHT_RESET);
  morph_result_t pending_results[$];

  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  binary_morphology_3x3 i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic bit in_core(int y, int x, int h, int w);
    return y >= 1 && y <= h - 2 && x >= 1 && x <= w - 2;
  endfunction

  // window covers rows r-2..r and columns c-2..c of the input position
  function automatic logic [7:0] morph_value(int y, int x, int r, int c, int h, int w);
    int py, px, wr, wc;
    if (!dilate_mode) begin
      if (in_core(y, x, h, w) && y == r - 1 && x == c - 1 && nb_window == WIN_FULL)
        return FG_PIXEL;
      return BG_PIXEL;
    end
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        py = y + dy;
        px = x + dx;
        wr = py - (r - 2);
        wc = px - (c - 2);
        if (in_core(py, px, h, w) && wr >= 0 && wr <= 2 && wc >= 0 && wc <= 2 &&
            nb_window[wr * 3 + wc])
          return FG_PIXEL;
      end
    end
    return BG_PIXEL;
  endfunction

  task automatic expect_result(input int y, input int x, input bit last,
                               input int r, input int c, input int h, input int w);
    morph_result_t res;
    res.value = morph_value(y, x, r, c, h, w);
    res.row   = 12'(y);
    res.col   = 10'(x);
    res.last  = last;
    pending_results.push_back(res);
  endtask

  task automatic apply_pixel(input logic [7:0] px);
    int w, h, r, c;
    logic fg, a, b;
    w = (cfg_width < WIDTH_MIN) ? WIDTH_MIN : (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
    h = (cfg_height < HEIGHT_MIN) ? HEIGHT_MIN :
        (cfg_height > HEIGHT_MAX) ? HEIGHT_MAX : cfg_height;
    fg = (px == FG_PIXEL);
    if (pos_col >= w) pos_col = 0;
    if (pos_row >= h) pos_row = 0;
    r = pos_row;
    c = pos_col;
    a = row_above[c];
    b = row_above2[c];
    nb_window = ((nb_window >> 1) & 9'h0DB) | {6'd0, b, 2'd0} | {3'd0, a, 5'd0} | {fg, 8'd0};
    row_above2[c] = a;
    row_above[c]  = fg;
    if (r >= 1 && c >= 1) begin
      expect_result(r - 1, c - 1, 1'b0, r, c, h, w);
      if (r == h - 1) expect_result(r, c - 1, 1'b0, r, c, h, w);
    end
    if (r >= 1 && c == w - 1) begin
      expect_result(r - 1, c, 1'b0, r, c, h, w);
      if (r == h - 1) expect_result(r, c, 1'b1, r, c, h, w);
    end
    pos_col++;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= h) pos_row = 0;
    end
  endtask

  // ---------------------------------------------------------------- drivers
  task automatic send_pixel(input logic [7:0] px);
    int gap;
    gap = 0;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= px;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    apply_pixel(px);
  endtask

  task automatic stream_pixels(input int count, input int fg_pct);
    for (int k = 0; k < count; k++)
      send_pixel(($urandom_range(99) < fg_pct) ? FG_PIXEL : 8'($urandom_range(255)));
  endtask

  // drains all outstanding results, then lets the pipeline settle
  task automatic await_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    await_idle();
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MODE:         dilate_mode = val[0];
      REG_FRAME_WIDTH:  cfg_width = val[10:0];
      REG_FRAME_HEIGHT: cfg_height = val;
      default:          return;
    endcase
    pos_row = 0;
    pos_col = 0;
    nb_window = '0;
  endtask

  // ---------------------------------------------------------------- receiver
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("%0t mismatch %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin : check_results
    morph_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata, 0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[7:0] != want.value)
          report_mismatch("out_pixel", m_axis_tdata[7:0], want.value);
        if (m_axis_tdata[19:8] != want.row)
          report_mismatch("out_row", m_axis_tdata[19:8], want.row);
        if (m_axis_tdata[29:20] != want.col)
          report_mismatch("out_col", m_axis_tdata[29:20], want.col);
        if (m_axis_tdata[31:30] != 2'b00)
          report_mismatch("tdata pad", m_axis_tdata[31:30], 0);
        if (m_axis_tlast != want.last)
          report_mismatch("frame_last", m_axis_tlast, want.last);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("** binary_morphology_3x3: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- tests
  // 640x480 erosion out of reset; the first row gives no results
  task automatic test_reset_defaults();
    stream_pixels(16, 50);
  endtask

  task automatic test_directed_frames();
    logic [7:0] ring [9]   = '{FG_PIXEL, FG_PIXEL, FG_PIXEL, FG_PIXEL, 8'hFE,
                               FG_PIXEL, FG_PIXEL, FG_PIXEL, FG_PIXEL};
    logic [7:0] center [9] = '{8'h00, 8'h01, 8'h7F, 8'h80, FG_PIXEL,
                               8'h02, 8'h40, 8'h04, 8'h08};
    cfg_write(REG_FRAME_WIDTH, 12'd3);
    cfg_write(REG_FRAME_HEIGHT, 12'd3);
    cfg_write(REG_MODE, 12'd0);
    // solid frame under erosion; an unmapped index must not restart the frame
    repeat (4) send_pixel(FG_PIXEL);
    cfg_write(REG_NONE, 12'hFFF);
    repeat (5) send_pixel(FG_PIXEL);
    cfg_write(REG_MODE, 12'd1);
    // border foreground alone must not dilate; then a lone center pixel
    foreach (ring[k]) send_pixel(ring[k]);
    foreach (center[k]) send_pixel(center[k]);
  endtask

  task automatic test_size_clamps();
    cfg_write(REG_MODE, 12'd1);
    cfg_write(REG_FRAME_WIDTH, 12'h801);
    cfg_write(REG_FRAME_HEIGHT, 12'd2);
    stream_pixels(9, 30);
    cfg_write(REG_FRAME_WIDTH, 12'h800);
    cfg_write(REG_FRAME_HEIGHT, 12'd0);
    stream_pixels(9, 30);
    cfg_write(REG_FRAME_WIDTH, 12'h7FF);
    stream_pixels(10, 3);
    cfg_write(REG_MODE, 12'd0);
    cfg_write(REG_FRAME_WIDTH, 12'd1025);
    cfg_write(REG_FRAME_HEIGHT, 12'hFFF);
    stream_pixels(10, 90);
    // tallest frame, narrow
    cfg_write(REG_FRAME_WIDTH, 12'd3);
    stream_pixels(10, 85);
  endtask

  task automatic test_random_frames(input int idle_pct, input int stall_pct, input int budget);
    int sent, w, h, n, fg_pct;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < budget) begin
      w = ($urandom_range(7) == 0) ? $urandom_range(10, 24) : $urandom_range(3, 9);
      h = $urandom_range(3, 6);
      fg_pct = ($urandom_range(2) == 0) ? 90 : $urandom_range(5, 60);
      cfg_write(REG_MODE, {11'($urandom_range(2047)), 1'($urandom_range(1))});
      cfg_write(REG_FRAME_WIDTH, {1'($urandom_range(1)), 11'(w)});
      cfg_write(REG_FRAME_HEIGHT, 12'(h));
      // mostly whole frames, sometimes back to back; the rest cut short
      n = ($urandom_range(3) == 0) ? $urandom_range(1, w * h - 1) : w * h * $urandom_range(1, 2);
      if (n > budget - sent) n = budget - sent;
      stream_pixels(n, fg_pct);
      sent += n;
    end
  endtask

  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cfg_write(REG_MODE, 12'd1);
    cfg_write(REG_FRAME_WIDTH, 12'd8);
    cfg_write(REG_FRAME_HEIGHT, 12'd6);
    hold_request = 1'b1;
    stream_pixels(48, 20);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_directed_frames();
    test_size_clamps();
    test_random_frames(0, 0, 36);
    test_random_frames(52, 0, 36);
    test_random_frames(0, 52, 36);
    test_random_frames(28, 28, 36);
    test_output_backpressure();
    await_idle();
    if (mismatches == 0) begin
      $display("** binary_morphology_3x3: PASSED **");
    end else begin
      $display("** binary_morphology_3x3: FAILED **");
    end
    $finish;
  end

endmodule
